### sv/lpr_pkg.sv
// Shared types for the LRU page replacement block.
// Used by lpr_cell and lru_page_replacement; no dependencies.
package lpr_pkg;

    // Per-cell control from the top level for one request.
    typedef struct packed {
        logic en;          // request accepted this cycle
        logic valid;       // cell holds a resident page
        logic tail;        // cell receives the requested page
        logic below_tail;  // cell may take its upper neighbor's page
    } lpr_ctl_t;

    localparam int OUT_PAGE_W = 16;
    localparam int OUT_OCC_W  = 4;
    localparam int CFG_W      = 4;
    localparam logic [CFG_W-1:0] ACTIVE_FRAMES_RST = 4'd4;

endpackage

### sv/lru_page_replacement.sv
// Top level of the LRU page replacement block: stream ports, occupancy,
// frame limit register and the chain of lpr_cell slots. Depends on lpr_pkg.
//
// Keeps up to FRAME_SLOTS resident pages ordered from least recent (slot 0)
// to most recent. Each request item on s_axis is compared against every slot
// at once; the slots then shift down by one toward the freed position and the
// request lands at the tail, so one item is taken every clock and its result
// appears on m_axis in the cycle after acceptance. An output register holds the
// result, so a new item is taken while the previous result is still being
// taken, and input stalls only when that register is full and not drained.
// The user must write the frame limit (active_frames, reset 4) on cfg only
// while idle; the block does not enforce this. 0 acts as 1 and values above
// FRAME_SLOTS act as FRAME_SLOTS. Lowering it below the occupancy makes a miss
// evict only the oldest page. evicted_page reads 0 when nothing is evicted.
module lru_page_replacement
    import lpr_pkg::*;
#(
    parameter int FRAME_SLOTS = 8,
    parameter int PAGE_BITS   = 16
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] page
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] hit, [1] evicted, [17:2] evicted_page, [33:18] lru_page,
    // [49:34] mru_page, [53:50] occupancy, [55:54] zero
    output logic [55:0] m_axis_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_data        // [3:0] active_frames
);

    localparam int CW = $clog2(FRAME_SLOTS + 1);
    localparam int EW = (CW > CFG_W) ? CW : CFG_W;

    logic [CFG_W-1:0]     active_frames_reg;
    logic [CW-1:0]        count_reg, count_next;
    logic                 out_valid_reg;
    logic [55:0]          out_data_reg, out_data_next;

    logic [PAGE_BITS-1:0] page;
    logic                 accept;
    logic [EW-1:0]        af_ext, lim_ext;
    logic [CW-1:0]        lim, tail_idx;
    logic                 hit, append, evict;

    logic [FRAME_SLOTS-1:0]     match;
    logic [FRAME_SLOTS:0]       shift;
    logic [PAGE_BITS-1:0]       entry      [FRAME_SLOTS];
    logic [PAGE_BITS-1:0]       entry_next [FRAME_SLOTS];
    logic [PAGE_BITS-1:0]       upper      [FRAME_SLOTS];
    lpr_ctl_t                   ctl        [FRAME_SLOTS];

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign page          = PAGE_BITS'(s_axis_tdata);

    assign af_ext  = EW'(active_frames_reg);
    assign lim_ext = (af_ext == '0) ? EW'(1) :
                     (af_ext > EW'(FRAME_SLOTS)) ? EW'(FRAME_SLOTS) : af_ext;
    assign lim     = lim_ext[CW-1:0];

    assign hit      = |match;
    assign append   = !hit && (count_reg < lim);
    assign evict    = !hit && !append;
    assign tail_idx = append ? count_reg : count_reg - CW'(1);
    assign shift[0] = evict;

    genvar i;
    generate
        for (i = 0; i < FRAME_SLOTS; i++)
        begin : g_cell
            assign ctl[i].en         = accept;
            assign ctl[i].valid      = CW'(i) < count_reg;
            assign ctl[i].tail       = tail_idx == CW'(i);
            assign ctl[i].below_tail = CW'(i + 1) < count_reg;

            if (i == FRAME_SLOTS - 1)
            begin : g_top
                assign upper[i] = '0;
            end
            else
            begin : g_mid
                assign upper[i] = entry[i + 1];
            end

            lpr_cell #(
                .PAGE_BITS (PAGE_BITS)
            ) u_cell (
                .clk         (clk),
                .ctl         (ctl[i]),
                .page        (page),
                .upper_entry (upper[i]),
                .shift_in    (shift[i]),
                .shift_out   (shift[i + 1]),
                .match       (match[i]),
                .entry       (entry[i]),
                .entry_next  (entry_next[i])
            );
        end
    endgenerate

    assign count_next = append ? count_reg + CW'(1) : count_reg;

    always_comb
    begin
        out_data_next        = '0;
        out_data_next[0]     = hit;
        out_data_next[1]     = evict;
        out_data_next[17:2]  = evict ? OUT_PAGE_W'(entry[0]) : '0;
        out_data_next[33:18] = OUT_PAGE_W'(entry_next[0]);
        out_data_next[49:34] = OUT_PAGE_W'(page);
        out_data_next[53:50] = OUT_OCC_W'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_frames_reg <= ACTIVE_FRAMES_RST;
            count_reg         <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                active_frames_reg <= cfg_data;
            end
            if (accept)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

### sv/lpr_cell.sv
// One slot of the recency chain: holds a page, compares it to the request
// and shifts down from its upper neighbor. Depends on lpr_pkg.
module lpr_cell
    import lpr_pkg::*;
#(
    parameter int PAGE_BITS = 16
)(
    input  logic                 clk,
    input  lpr_ctl_t             ctl,
    input  logic [PAGE_BITS-1:0] page,
    input  logic [PAGE_BITS-1:0] upper_entry,
    input  logic                 shift_in,
    output logic                 shift_out,
    output logic                 match,
    output logic [PAGE_BITS-1:0] entry,
    output logic [PAGE_BITS-1:0] entry_next
);

    logic [PAGE_BITS-1:0] entry_reg;

    assign match     = ctl.valid && (entry_reg == page);
    // once the hit slot (or an eviction) is at or below us, every slot shifts down
    assign shift_out = shift_in | match;

    always_comb
    begin
        priority if (ctl.tail)
        begin
            entry_next = page;
        end
        else if (shift_out && ctl.below_tail)
        begin
            entry_next = upper_entry;
        end
        else
        begin
            entry_next = entry_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            entry_reg <= entry_next;
        end
    end

    assign entry = entry_reg;

endmodule
